FILE: src/rmm_pkg.sv
// shared types and constants for the rgb min-max contrast stretch block
package rmm_pkg;

  localparam int unsigned ComponentBits = 8;
  localparam int unsigned NumChan       = 3;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned CfgIndexBits  = 2;

  typedef logic [ComponentBits-1:0] comp_t;
  typedef logic [CfgIndexBits-1:0]  cfg_index_t;

  localparam comp_t CompMax = '1;

  localparam cfg_index_t RegOutMin = cfg_index_t'(0);
  localparam cfg_index_t RegOutMax = cfg_index_t'(1);

  typedef struct packed {
    logic  func;
    logic  start_frame;
    comp_t red_in;
    comp_t green_in;
    comp_t blue_in;
  } in_item_t;

  typedef struct packed {
    comp_t red_out;
    comp_t green_out;
    comp_t blue_out;
  } out_item_t;

  typedef struct packed {
    comp_t out_min;
    comp_t out_max;
  } cfg_regs_t;

  // one channel of a pending stretch job, already clamped against its range
  typedef struct packed {
    logic  flat;
    comp_t offset;
    comp_t divisor;
  } chan_job_t;

  typedef struct packed {
    chan_job_t [NumChan-1:0] chan;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: src/rmm_front.sv
// front end: min/max trackers and preparation of stretch jobs
module rmm_front import rmm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     job_push_o,
  output job_t     job_o
);

  comp_t lo_q [NumChan];
  comp_t hi_q [NumChan];
  comp_t lo_d [NumChan];
  comp_t hi_d [NumChan];
  comp_t val  [NumChan];

  assign val[0] = item_i.red_in;
  assign val[1] = item_i.green_in;
  assign val[2] = item_i.blue_in;

  assign job_push_o = accept_i & item_i.func;

  always_comb begin
    comp_t base_lo;
    comp_t base_hi;
    comp_t clamped;
    for (int c = 0; c < NumChan; c++) begin
      // start flag reloads the trackers before this pixel counts
      base_lo = item_i.start_frame ? CompMax : lo_q[c];
      base_hi = item_i.start_frame ? '0 : hi_q[c];
      lo_d[c] = (val[c] < base_lo) ? val[c] : base_lo;
      hi_d[c] = (val[c] > base_hi) ? val[c] : base_hi;

      if (val[c] < lo_q[c]) begin
        clamped = lo_q[c];
      end else if (val[c] > hi_q[c]) begin
        clamped = hi_q[c];
      end else begin
        clamped = val[c];
      end
      job_o.chan[c].flat    = (hi_q[c] <= lo_q[c]);
      job_o.chan[c].offset  = clamped - lo_q[c];
      job_o.chan[c].divisor = hi_q[c] - lo_q[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChan; c++) begin
        lo_q[c] <= CompMax;
        hi_q[c] <= '0;
      end
    end else if (accept_i && !item_i.func) begin
      for (int c = 0; c < NumChan; c++) begin
        lo_q[c] <= lo_d[c];
        hi_q[c] <= hi_d[c];
      end
    end
  end

endmodule

FILE: src/rmm_fifo.sv
// short job queue between the front end and the divider back end
module rmm_fifo import rmm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  job_t          data_i,
  input  logic          pop_i,
  output job_t          data_o,
  output queue_status_t status_o
);

  localparam int unsigned PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  job_t                entries [QueueDepth];
  logic [PtrBits-1:0]  wptr_q, rptr_q;
  logic [CntBits-1:0]  cnt_q;

  assign status_o.full  = (cnt_q == CntBits'(QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign data_o         = entries[rptr_q];

  function automatic logic [PtrBits-1:0] next_ptr(input logic [PtrBits-1:0] p);
    next_ptr = (p == PtrBits'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= next_ptr(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= next_ptr(rptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: src/rmm_back.sv
// back end: scale multiply, bit-serial floor division and output word register
module rmm_back import rmm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_regs_t cfg_i,
  input  job_t      job_i,
  input  logic      job_empty_i,
  output logic      job_pop_o,
  output out_item_t result_o,
  output logic      empty_o,
  input  logic      pop_i
);

  localparam int unsigned N       = ComponentBits;
  localparam int unsigned CntBits = $clog2(N + 1);

  typedef enum logic [1:0] {StIdle, StMul, StDiv, StFin} state_e;

  state_e              state_q;
  logic [CntBits-1:0]  cnt_q;
  job_t                job_q;
  comp_t               rem_q [NumChan];
  comp_t               sh_q  [NumChan];
  comp_t               rem_d [NumChan];
  comp_t               sh_d  [NumChan];
  comp_t               res   [NumChan];
  logic                out_valid_q;
  out_item_t           out_q;

  logic signed [N:0]   diff;
  logic                neg;
  comp_t               absd;
  logic                load_out;

  assign diff = $signed({1'b0, cfg_i.out_max}) - $signed({1'b0, cfg_i.out_min});
  assign neg  = diff[N];
  always_comb begin
    logic signed [N:0] negd;
    negd = -diff;
    absd = neg ? negd[N-1:0] : diff[N-1:0];
  end

  assign job_pop_o = (state_q == StIdle) && !job_empty_i;
  assign load_out  = (state_q == StFin) && (!out_valid_q || pop_i);
  assign empty_o   = !out_valid_q;
  assign result_o  = out_q;

  // one restoring step per lane and cycle
  always_comb begin
    logic [N:0]   t;
    logic [N:0]   tsub;
    logic         ge;
    logic [2*N-1:0] mag;
    for (int c = 0; c < NumChan; c++) begin
      mag  = {{N{1'b0}}, job_q.chan[c].offset} * {{N{1'b0}}, absd};
      t    = {rem_q[c], sh_q[c][N-1]};
      tsub = t - {1'b0, job_q.chan[c].divisor};
      ge   = (t >= {1'b0, job_q.chan[c].divisor});
      if (state_q == StMul) begin
        rem_d[c] = mag[2*N-1:N];
        sh_d[c]  = mag[N-1:0];
      end else begin
        rem_d[c] = ge ? tsub[N-1:0] : t[N-1:0];
        sh_d[c]  = comp_t'({sh_q[c], ge});
      end
    end
  end

  // floor correction, offset by out_min and saturation; flat channels give out_min
  always_comb begin
    logic signed [N+1:0] qs;
    logic signed [N+1:0] s;
    logic signed [N+1:0] r;
    for (int c = 0; c < NumChan; c++) begin
      qs = $signed({2'b00, sh_q[c]});
      s  = neg ? (-qs - $signed({{(N+1){1'b0}}, |rem_q[c]})) : qs;
      r  = $signed({2'b00, cfg_i.out_min}) + s;
      if (job_q.chan[c].flat) begin
        res[c] = cfg_i.out_min;
      end else if (r < 0) begin
        res[c] = '0;
      end else if (r > $signed({2'b00, CompMax})) begin
        res[c] = CompMax;
      end else begin
        res[c] = r[N-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (state_q == StMul || state_q == StDiv) begin
      for (int c = 0; c < NumChan; c++) begin
        rem_q[c] <= rem_d[c];
        sh_q[c]  <= sh_d[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (!job_empty_i) begin
            state_q <= StMul;
          end
        end
        StMul: begin
          cnt_q   <= CntBits'(N);
          state_q <= StDiv;
        end
        StDiv: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntBits'(1)) begin
            state_q <= StFin;
          end
        end
        StFin: begin
          if (load_out) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase

      if (load_out) begin
        out_valid_q     <= 1'b1;
        out_q.red_out   <= res[0];
        out_q.green_out <= res[1];
        out_q.blue_out  <= res[2];
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

FILE: src/rgb_min_max_contrast_stretch.sv
// top level of the rgb min-max contrast stretch block
//
// the frame is sent twice through the push/full input queue. measure words
// (func low) update per-channel min/max trackers and give no result; a set
// start_frame reloads the trackers first. stretch words (func high) give one
// result word on the empty/pop output side.
// out_min and out_max are written over the cfg_valid_i/cfg_ready_o port,
// index 0 and 1; other indexes are dropped. cfg_ready_o is always high.
// measure words are taken one per cycle while full is low. a stretch word is
// snapshotted against the trackers at push and queued (two entries); the back
// end then takes it, multiplies, finds one quotient bit per cycle in the
// divider and finishes, and takes the next job only once it is back in idle.
// a result that is not popped holds in the output register; the back end
// waits, the queue fills and full rises, which also holds off measure words.
// reset clears the trackers to 255/0, out_min to 0 and out_max to 255, and
// leaves the block empty and ready.
module rgb_min_max_contrast_stretch import rmm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  in_item_t   pixel_i,
  output logic       empty,
  input  logic       pop,
  output out_item_t  result_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  cfg_index_t cfg_index_i,
  input  comp_t      cfg_data_i
);

  cfg_regs_t     cfg_q;
  logic          accept;
  logic          q_push;
  logic          q_pop;
  job_t          q_wdata;
  job_t          q_rdata;
  queue_status_t q_status;

  assign cfg_ready_o = 1'b1;
  assign full        = q_status.full;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.out_min <= '0;
      cfg_q.out_max <= CompMax;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == RegOutMin) begin
        cfg_q.out_min <= cfg_data_i;
      end else if (cfg_index_i == RegOutMax) begin
        cfg_q.out_max <= cfg_data_i;
      end
    end
  end

  rmm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (pixel_i),
    .job_push_o (q_push),
    .job_o      (q_wdata)
  );

  rmm_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .data_i   (q_wdata),
    .pop_i    (q_pop),
    .data_o   (q_rdata),
    .status_o (q_status)
  );

  rmm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (q_rdata),
    .job_empty_i (q_status.empty),
    .job_pop_o   (q_pop),
    .result_o    (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  // a waiting result word holds until it is popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("result word changed while waiting");

  // back end only takes a job that the queue holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("job queue popped while empty");

  // front end never writes a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_status.full)
    else $error("job queue written while full");

endmodule
